// ===== hw/rtl/mice_pkg.sv =====
// shared types and constants for the mic-e position decoder
package mice_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_BAD_LON    = 2'd2
  } status_t;

  // decoded destination character
  typedef struct packed {
    logic [3:0] digit;
    logic       flag;
  } char_info_t;

  // destination character classes
  localparam logic [7:0] CHAR_NUM_LO     = 8'h30;
  localparam logic [7:0] CHAR_NUM_HI     = 8'h39;
  localparam logic [7:0] CHAR_ALPHA_LO   = 8'h41;
  localparam logic [7:0] CHAR_ALPHA_HI   = 8'h4a;
  localparam logic [7:0] CHAR_FLAG_LO    = 8'h50;
  localparam logic [7:0] CHAR_FLAG_NUMHI = 8'h59;
  localparam logic [7:0] CHAR_FLAG_HI    = 8'h5a;

  localparam int          DEST_CHARS   = 6;
  localparam logic [5:0]  DEST_LENGTH  = 6'd6;
  localparam int          DIGIT_RADIX  = 10;

  // longitude byte encoding and wrap rules
  localparam logic [7:0] LON_BYTE_OFFSET = 8'd28;
  localparam logic [7:0] LON_BYTE_MAX    = 8'd127;
  localparam logic [7:0] LON_DEG_OFFSET  = 8'd100;
  localparam logic [7:0] LON_DEG_WRAP_HI = 8'd190;
  localparam logic [7:0] LON_DEG_WRAP_LO = 8'd180;
  localparam logic [7:0] LON_DEG_SUB_LO  = 8'd80;
  localparam logic [6:0] LON_MIN_WRAP    = 7'd60;

  // microdegree scaling
  localparam int UDEG_PER_DEG   = 1000000;
  localparam int MIN_STEP_UDEG  = 3 * UDEG_PER_DEG / 60;
  localparam int MIN_REM1_UDEG  = UDEG_PER_DEG / 60;
  localparam int MIN_REM2_UDEG  = 2 * UDEG_PER_DEG / 60;
  localparam int HUN_STEP_UDEG  = 3 * UDEG_PER_DEG / 6000;
  localparam int HUN_REM1_UDEG  = UDEG_PER_DEG / 6000;
  localparam int HUN_REM2_UDEG  = 2 * UDEG_PER_DEG / 6000;

  // divide by three for values below 128: (x * 171) >> 9
  localparam int RECIP3_MUL   = 171;
  localparam int RECIP3_SHIFT = 9;

endpackage

// ===== hw/rtl/mice_char_dec.sv =====
// decode of one destination character into latitude digit and flag
module mice_char_dec (
  input  logic [7:0]          char_code,
  output mice_pkg::char_info_t info
);

  always_comb begin
    info.digit = 4'd0;
    info.flag  = 1'b0;
    if (char_code inside {[mice_pkg::CHAR_NUM_LO:mice_pkg::CHAR_NUM_HI]}) begin
      info.digit = char_code[3:0];
    end else if (char_code inside
                 {[mice_pkg::CHAR_ALPHA_LO:mice_pkg::CHAR_ALPHA_HI]}) begin
      info.digit = char_code[3:0] - 4'd1;
    end else if (char_code inside
                 {[mice_pkg::CHAR_FLAG_LO:mice_pkg::CHAR_FLAG_NUMHI]}) begin
      info.digit = char_code[3:0];
    end
    if (char_code inside {[mice_pkg::CHAR_FLAG_LO:mice_pkg::CHAR_FLAG_HI]}) begin
      info.flag = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/mice_udeg_conv.sv =====
// degrees, minutes and hundredths of minutes to unsigned microdegrees
module mice_udeg_conv (
  input  logic [7:0]  deg,
  input  logic [6:0]  minutes,
  input  logic [6:0]  hundredths,
  output logic [27:0] udeg
);

  logic [14:0] min_prod;
  logic [14:0] hun_prod;
  logic [5:0]  min_q;
  logic [5:0]  hun_q;
  logic [1:0]  min_r;
  logic [1:0]  hun_r;
  logic [20:0] min_rem_udeg;
  logic [14:0] hun_rem_udeg;
  logic [20:0] min_udeg;
  logic [14:0] hun_udeg;
  logic [27:0] deg_udeg;

  // split into three-unit steps plus remainder, exact truncation
  assign min_prod = 15'(minutes) * 15'(mice_pkg::RECIP3_MUL);
  assign hun_prod = 15'(hundredths) * 15'(mice_pkg::RECIP3_MUL);
  assign min_q    = min_prod[mice_pkg::RECIP3_SHIFT +: 6];
  assign hun_q    = hun_prod[mice_pkg::RECIP3_SHIFT +: 6];
  assign min_r    = 2'(minutes - 7'(min_q * 3));
  assign hun_r    = 2'(hundredths - 7'(hun_q * 3));

  always_comb begin
    case (min_r)
      2'd1:    min_rem_udeg = 21'(mice_pkg::MIN_REM1_UDEG);
      2'd2:    min_rem_udeg = 21'(mice_pkg::MIN_REM2_UDEG);
      default: min_rem_udeg = 21'd0;
    endcase
    case (hun_r)
      2'd1:    hun_rem_udeg = 15'(mice_pkg::HUN_REM1_UDEG);
      2'd2:    hun_rem_udeg = 15'(mice_pkg::HUN_REM2_UDEG);
      default: hun_rem_udeg = 15'd0;
    endcase
  end

  assign min_udeg = 21'(min_q) * 21'(mice_pkg::MIN_STEP_UDEG) + min_rem_udeg;
  assign hun_udeg = 15'(hun_q) * 15'(mice_pkg::HUN_STEP_UDEG) + hun_rem_udeg;
  assign deg_udeg = 28'(deg) * 28'(mice_pkg::UDEG_PER_DEG);

  assign udeg = deg_udeg + 28'(min_udeg) + 28'(hun_udeg);

endmodule

// ===== hw/rtl/mic_e_position_decode_top.sv =====
// mic-e position decoder top level: input register, decode logic, result register
//
// Decodes the latitude and longitude of one Mic-E position per transaction.
// The six destination characters give the latitude digits and the north,
// longitude +100 degree and west flags; the three information bytes give
// longitude degrees, minutes and hundredths (each offset by 28). Results are
// in signed microdegrees with a status: ok, destination length not six (both
// positions zero), or a longitude byte outside 28..127 (latitude still
// decoded, longitude zero). The block is a two-register pipeline, an input
// register and a result register, with all decoding in one combinational
// pass between them. An accepted transaction waits in the input register
// until the result register is free. A new transaction can be accepted every
// cycle unless the output stalls; the result register drains independently,
// so the input side keeps accepting while a result waits, until both are full.
module mic_e_position_decode_top (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  dest_char_0,
  input  logic [7:0]  dest_char_1,
  input  logic [7:0]  dest_char_2,
  input  logic [7:0]  dest_char_3,
  input  logic [7:0]  dest_char_4,
  input  logic [7:0]  dest_char_5,
  input  logic [5:0]  dest_length,
  input  logic [7:0]  lon_degree_byte,
  input  logic [7:0]  lon_minute_byte,
  input  logic [7:0]  lon_hundredth_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic signed [27:0] latitude_udeg,
  output logic signed [28:0] longitude_udeg
);

  // input register stage
  logic        pipe_valid;
  logic [7:0]  pipe_char [mice_pkg::DEST_CHARS];
  logic [5:0]  pipe_length;
  logic [7:0]  pipe_lon_deg;
  logic [7:0]  pipe_lon_min;
  logic [7:0]  pipe_lon_hun;

  logic        out_free;
  logic        pipe_move;

  // decode signals
  mice_pkg::char_info_t char_info [mice_pkg::DEST_CHARS];
  logic [6:0]  lat_deg;
  logic [6:0]  lat_min;
  logic [6:0]  lat_hun;
  logic [27:0] lat_mag;
  logic        lon_range_ok;
  logic [7:0]  lon_deg_base;
  logic [7:0]  lon_deg_off;
  logic [7:0]  lon_deg;
  logic [6:0]  lon_min_base;
  logic [6:0]  lon_min;
  logic [6:0]  lon_hun;
  logic [27:0] lon_mag;

  mice_pkg::status_t  status_next;
  logic signed [27:0] latitude_next;
  logic signed [28:0] longitude_next;

  // handshake: the result register takes a new transaction when empty or draining
  assign out_free  = !out_valid || out_ready;
  assign pipe_move = pipe_valid && out_free;
  assign in_ready  = !pipe_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_ready) begin
      pipe_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pipe_char[0] <= dest_char_0;
      pipe_char[1] <= dest_char_1;
      pipe_char[2] <= dest_char_2;
      pipe_char[3] <= dest_char_3;
      pipe_char[4] <= dest_char_4;
      pipe_char[5] <= dest_char_5;
      pipe_length  <= dest_length;
      pipe_lon_deg <= lon_degree_byte;
      pipe_lon_min <= lon_minute_byte;
      pipe_lon_hun <= lon_hundredth_byte;
    end
  end

  // per-character digit and flag decode
  for (genvar i = 0; i < mice_pkg::DEST_CHARS; i++) begin : g_char
    mice_char_dec u_char_dec (
      .char_code (pipe_char[i]),
      .info      (char_info[i])
    );
  end

  // latitude digits pair up into degrees, minutes and hundredths
  assign lat_deg = 7'(char_info[0].digit) * 7'(mice_pkg::DIGIT_RADIX)
                 + 7'(char_info[1].digit);
  assign lat_min = 7'(char_info[2].digit) * 7'(mice_pkg::DIGIT_RADIX)
                 + 7'(char_info[3].digit);
  assign lat_hun = 7'(char_info[4].digit) * 7'(mice_pkg::DIGIT_RADIX)
                 + 7'(char_info[5].digit);

  mice_udeg_conv u_lat_conv (
    .deg        ({1'b0, lat_deg}),
    .minutes    (lat_min),
    .hundredths (lat_hun),
    .udeg       (lat_mag)
  );

  // longitude bytes must all sit in 28..127
  assign lon_range_ok = (pipe_lon_deg >= mice_pkg::LON_BYTE_OFFSET)
                     && (pipe_lon_deg <= mice_pkg::LON_BYTE_MAX)
                     && (pipe_lon_min >= mice_pkg::LON_BYTE_OFFSET)
                     && (pipe_lon_min <= mice_pkg::LON_BYTE_MAX)
                     && (pipe_lon_hun >= mice_pkg::LON_BYTE_OFFSET)
                     && (pipe_lon_hun <= mice_pkg::LON_BYTE_MAX);

  // degree wrap: offset flag adds 100, then 190+ and 180..189 fold back
  assign lon_deg_base = pipe_lon_deg - mice_pkg::LON_BYTE_OFFSET;
  assign lon_deg_off  = char_info[4].flag ? lon_deg_base + mice_pkg::LON_DEG_OFFSET
                                          : lon_deg_base;

  always_comb begin
    if (lon_deg_off >= mice_pkg::LON_DEG_WRAP_HI) begin
      lon_deg = lon_deg_off - mice_pkg::LON_DEG_WRAP_HI;
    end else if (lon_deg_off >= mice_pkg::LON_DEG_WRAP_LO) begin
      lon_deg = lon_deg_off - mice_pkg::LON_DEG_SUB_LO;
    end else begin
      lon_deg = lon_deg_off;
    end
  end

  // minute wrap: 60 and above lose 60
  assign lon_min_base = 7'(pipe_lon_min - mice_pkg::LON_BYTE_OFFSET);
  assign lon_min      = (lon_min_base >= mice_pkg::LON_MIN_WRAP)
                      ? lon_min_base - mice_pkg::LON_MIN_WRAP : lon_min_base;
  assign lon_hun      = 7'(pipe_lon_hun - mice_pkg::LON_BYTE_OFFSET);

  mice_udeg_conv u_lon_conv (
    .deg        (lon_deg),
    .minutes    (lon_min),
    .hundredths (lon_hun),
    .udeg       (lon_mag)
  );

  // status and signs; length check takes priority over the longitude check
  always_comb begin
    status_next    = mice_pkg::STATUS_OK;
    latitude_next  = '0;
    longitude_next = '0;
    if (pipe_length != mice_pkg::DEST_LENGTH) begin
      status_next = mice_pkg::STATUS_BAD_LENGTH;
    end else begin
      latitude_next = char_info[3].flag ? $signed(lat_mag) : -$signed(lat_mag);
      if (!lon_range_ok) begin
        status_next = mice_pkg::STATUS_BAD_LON;
      end else begin
        longitude_next = char_info[5].flag ? -$signed({1'b0, lon_mag})
                                           : $signed({1'b0, lon_mag});
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_move) begin
      status         <= status_next;
      latitude_udeg  <= latitude_next;
      longitude_udeg <= longitude_next;
    end
  end

`ifndef SYNTHESIS
  // a bad destination length clears both positions
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mice_pkg::STATUS_BAD_LENGTH)
      |-> (latitude_udeg == 28'sd0) && (longitude_udeg == 29'sd0))
    else $error("bad length result carries a nonzero position");

  // any error clears the longitude
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != mice_pkg::STATUS_OK) |-> (longitude_udeg == 29'sd0))
    else $error("error result carries a nonzero longitude");

  // decoded latitude stays within the encodable span
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (latitude_udeg <= 28'sd100666500)
               && (latitude_udeg >= -28'sd100666500))
    else $error("latitude outside the encodable span");

  // a held input register keeps its transaction while the result side stalls
  assert property (@(posedge clk) disable iff (rst)
    pipe_valid && !out_free |=> pipe_valid && $stable(pipe_length)
                                && $stable(pipe_lon_deg))
    else $error("input register lost a stalled transaction");

  // pipeline is empty after reset
  assert property (@(posedge clk)
    rst |=> !pipe_valid && !out_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== verif/tb_mic_e_position_decode_top.sv =====
// self-checking testbench for the mic-e position decoder: directed and random positions
`timescale 1ns / 100ps

module tb_mic_e_position_decode_top;

  // clock, run length and idling shape
  localparam time CLK_PERIOD   = 8ns;
  localparam int  RESET_CYCLES = 3;
  localparam int  RANDOM_ITEMS = 1500;
  localparam int  CALM_ITEMS   = 150;     // no idling once this few positions are left
  localparam int  HOLD_AFTER   = 300;     // long receiver hold-off after this many fixes
  localparam int  HOLD_CYCLES  = 60;
  localparam int  DRAIN_CYCLES = 8;       // two-register pipeline, with margin
  localparam int  LIMIT_CYCLES = 100000;

  // destination character set
  localparam logic [7:0] CHR_0 = 8'h30;
  localparam logic [7:0] CHR_1 = 8'h31;
  localparam logic [7:0] CHR_2 = 8'h32;
  localparam logic [7:0] CHR_3 = 8'h33;
  localparam logic [7:0] CHR_4 = 8'h34;
  localparam logic [7:0] CHR_5 = 8'h35;
  localparam logic [7:0] CHR_8 = 8'h38;
  localparam logic [7:0] CHR_9 = 8'h39;
  localparam logic [7:0] CHR_A = 8'h41;
  localparam logic [7:0] CHR_J = 8'h4a;
  localparam logic [7:0] CHR_K = 8'h4b;
  localparam logic [7:0] CHR_L = 8'h4c;
  localparam logic [7:0] CHR_P = 8'h50;
  localparam logic [7:0] CHR_Y = 8'h59;
  localparam logic [7:0] CHR_Z = 8'h5a;

  // info byte encoding and longitude wrap
  localparam logic [5:0] LEN_OK        = 6'd6;
  localparam int         LON_MIN_BYTE  = 28;
  localparam int         LON_MAX_BYTE  = 127;
  localparam int         DEG_OFFSET    = 100;
  localparam int         DEG_WRAP_HI   = 190;
  localparam int         DEG_WRAP_LO   = 180;
  localparam int         DEG_SUB_LO    = 80;
  localparam int         MIN_WRAP      = 60;
  localparam longint     MICRO         = 1000000;

  // one encoded position as it goes into the block
  typedef struct packed {
    logic [5:0][7:0] ch;
    logic [5:0]      len;
    logic [7:0]      lon_deg;
    logic [7:0]      lon_min;
    logic [7:0]      lon_hun;
  } position_t;

  // one decoded fix as it should leave the block
  typedef struct packed {
    mice_pkg::status_t  status;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
  } fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  dest_char_0 = '0;
  logic [7:0]  dest_char_1 = '0;
  logic [7:0]  dest_char_2 = '0;
  logic [7:0]  dest_char_3 = '0;
  logic [7:0]  dest_char_4 = '0;
  logic [7:0]  dest_char_5 = '0;
  logic [5:0]  dest_length = '0;
  logic [7:0]  lon_degree_byte = '0;
  logic [7:0]  lon_minute_byte = '0;
  logic [7:0]  lon_hundredth_byte = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic signed [27:0] latitude_udeg;
  logic signed [28:0] longitude_udeg;

  // positions waiting to be offered, fixes waiting to come out
  position_t position_q[$];
  fix_t      expected_fix_q[$];

  int        positions_queued   = 0;
  int        positions_accepted = 0;
  int        fixes_checked      = 0;
  int        err_count          = 0;
  int unsigned tick             = 0;

  mic_e_position_decode_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .dest_char_0        (dest_char_0),
    .dest_char_1        (dest_char_1),
    .dest_char_2        (dest_char_2),
    .dest_char_3        (dest_char_3),
    .dest_char_4        (dest_char_4),
    .dest_char_5        (dest_char_5),
    .dest_length        (dest_length),
    .lon_degree_byte    (lon_degree_byte),
    .lon_minute_byte    (lon_minute_byte),
    .lon_hundredth_byte (lon_hundredth_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .latitude_udeg      (latitude_udeg),
    .longitude_udeg     (longitude_udeg)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // free-running cycle count, shared by both sides to open and close idling windows
  always @(posedge clk) begin
    tick <= tick + 1;
  end

  // ---------------------------------------------------------------------------
  // decode prediction
  // ---------------------------------------------------------------------------

  // latitude digit carried by a destination character
  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c >= CHR_0 && c <= CHR_9) return c - CHR_0;
    if (c >= CHR_A && c <= CHR_J) return c - CHR_A;
    if (c >= CHR_P && c <= CHR_Y) return c - CHR_P;
    return 0;   // K, L, Z and anything outside the set
  endfunction

  // north / offset / west flag: P through Z
  function automatic bit char_flag(input logic [7:0] c);
    return c >= CHR_P && c <= CHR_Z;
  endfunction

  function automatic bit lon_byte_ok(input logic [7:0] b);
    return b >= LON_MIN_BYTE && b <= LON_MAX_BYTE;
  endfunction

  // degrees, minutes, hundredths of minutes to microdegrees, each term truncated
  function automatic longint to_micro(input int unsigned deg, input int unsigned mins,
                                      input int unsigned hun);
    return longint'(deg) * MICRO + (longint'(mins) * MICRO) / 60
         + (longint'(hun) * MICRO) / 6000;
  endfunction

  function automatic fix_t decode_position(input position_t p);
    fix_t        f;
    int unsigned deg, mins, hun;
    longint      lat, lon;
    f.status = mice_pkg::STATUS_OK;
    f.lat    = '0;
    f.lon    = '0;
    if (p.len != LEN_OK) begin
      // length is checked first, both positions stay zero
      f.status = mice_pkg::STATUS_BAD_LENGTH;
    end else begin
      deg  = char_digit(p.ch[0]) * 10 + char_digit(p.ch[1]);
      mins = char_digit(p.ch[2]) * 10 + char_digit(p.ch[3]);
      hun  = char_digit(p.ch[4]) * 10 + char_digit(p.ch[5]);
      lat  = to_micro(deg, mins, hun);
      if (!char_flag(p.ch[3])) lat = -lat;   // south
      f.lat = lat[27:0];
      if (!lon_byte_ok(p.lon_deg) || !lon_byte_ok(p.lon_min) || !lon_byte_ok(p.lon_hun)) begin
        // latitude still decoded, longitude stays zero
        f.status = mice_pkg::STATUS_BAD_LON;
      end else begin
        deg  = p.lon_deg - LON_MIN_BYTE;
        mins = p.lon_min - LON_MIN_BYTE;
        hun  = p.lon_hun - LON_MIN_BYTE;
        if (char_flag(p.ch[4])) deg = deg + DEG_OFFSET;
        if (deg >= DEG_WRAP_HI) deg = deg - DEG_WRAP_HI;
        else if (deg >= DEG_WRAP_LO) deg = deg - DEG_SUB_LO;
        if (mins >= MIN_WRAP) mins = mins - MIN_WRAP;
        lon = to_micro(deg, mins, hun);
        if (char_flag(p.ch[5])) lon = -lon;  // west
        f.lon = lon[28:0];
      end
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic bit idle_window();
    return (tick % 256) < 170;
  endfunction

  task automatic queue_position(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2, input logic [7:0] c3,
                                input logic [7:0] c4, input logic [7:0] c5,
                                input logic [5:0] len, input logic [7:0] ld,
                                input logic [7:0] lm, input logic [7:0] ls);
    position_t p;
    p.ch      = {c5, c4, c3, c2, c1, c0};
    p.len     = len;
    p.lon_deg = ld;
    p.lon_min = lm;
    p.lon_hun = ls;
    position_q.push_back(p);
    positions_queued++;
  endtask

  // mostly valid characters, with flag letters often, and some arbitrary bytes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'(CHR_0 + $urandom_range(0, 9));
      3, 4:    return 8'(CHR_A + $urandom_range(0, 9));
      5, 6, 7: return 8'(CHR_P + $urandom_range(0, 9));
      8: begin
        case ($urandom_range(0, 2))
          0:       return CHR_K;
          1:       return CHR_L;
          default: return CHR_Z;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_random_position();
    logic [7:0] c [6];
    logic [7:0] b [3];
    logic [5:0] len;
    int         k;
    for (k = 0; k < 6; k++) c[k] = pick_char();
    len = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63)) : LEN_OK;
    for (k = 0; k < 3; k++) b[k] = 8'($urandom_range(LON_MIN_BYTE, LON_MAX_BYTE));
    // now and then break one info byte
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0:       b[k] = 8'($urandom_range(0, LON_MIN_BYTE - 1));
        1:       b[k] = 8'($urandom_range(LON_MAX_BYTE + 1, 255));
        default: b[k] = 8'($urandom_range(0, 255));
      endcase
    end
    queue_position(c[0], c[1], c[2], c[3], c[4], c[5], len, b[0], b[1], b[2]);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued positions, random gaps between transactions
  // ---------------------------------------------------------------------------
  position_t offered;
  int        send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // accepted transaction: its fix is now owed
      if (in_valid && in_ready) begin
        expected_fix_q.push_back(decode_position(offered));
        positions_accepted++;
      end
      // load the next position once the current one is gone
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || position_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          offered = position_q.pop_front();
          dest_char_0        <= offered.ch[0];
          dest_char_1        <= offered.ch[1];
          dest_char_2        <= offered.ch[2];
          dest_char_3        <= offered.ch[3];
          dest_char_4        <= offered.ch[4];
          dest_char_5        <= offered.ch[5];
          dest_length        <= offered.len;
          lon_degree_byte    <= offered.lon_deg;
          lon_minute_byte    <= offered.lon_min;
          lon_hundredth_byte <= offered.lon_hun;
          in_valid           <= 1'b1;
          // gap after this one, only outside the calm tail
          if (position_q.size() > CALM_ITEMS && idle_window() && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 4);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each fix, random stalls and one long hold-off
  // ---------------------------------------------------------------------------
  fix_t want;
  int   stall_left = 0;
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fix_q.size() == 0) begin
          $error("fix with no position pending: status %0d lat %0d lon %0d",
                 status, latitude_udeg, longitude_udeg);
          err_count++;
        end else begin
          want = expected_fix_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            err_count++;
          end
          if (latitude_udeg !== want.lat) begin
            $error("latitude_udeg: expected %0d, actual %0d", want.lat, latitude_udeg);
            err_count++;
          end
          if (longitude_udeg !== want.lon) begin
            $error("longitude_udeg: expected %0d, actual %0d", want.lon, longitude_udeg);
            err_count++;
          end
          fixes_checked++;
        end
      end
      // next cycle's ready
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && fixes_checked >= HOLD_AFTER) begin
        // long hold-off: the sender keeps offering and the pipeline backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (position_q.size() > CALM_ITEMS && idle_window()
                   && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;

    // all zero digits, south and east, smallest info bytes
    queue_position(CHR_0, CHR_0, CHR_0, CHR_0, CHR_0, CHR_0, LEN_OK, 8'd28, 8'd28, 8'd28);
    // all nines with every flag set: offset pushes degrees past 190
    queue_position(CHR_9, CHR_9, CHR_9, CHR_Y, CHR_Y, CHR_Y, LEN_OK, 8'd127, 8'd127, 8'd127);
    // letter digits, K and L give zero without flag, Z gives zero with flag
    queue_position(CHR_A, CHR_J, 8'h45, CHR_K, CHR_L, CHR_Z, LEN_OK, 8'd60, 8'd70, 8'd80);
    queue_position(CHR_Z, CHR_K, CHR_L, CHR_Z, CHR_Z, CHR_K, LEN_OK, 8'd100, 8'd50, 8'd40);
    // offset flag, degrees land on 180 and 189
    queue_position(CHR_4, CHR_5, CHR_3, CHR_P, CHR_P, CHR_0, LEN_OK, 8'd108, 8'd30, 8'd30);
    queue_position(CHR_1, CHR_2, CHR_3, CHR_4, CHR_P, CHR_P, LEN_OK, 8'd117, 8'd40, 8'd99);
    // offset flag, degrees land on 190 and 179
    queue_position(CHR_8, CHR_9, CHR_5, CHR_Y, CHR_Y, CHR_P, LEN_OK, 8'd118, 8'd87, 8'd127);
    queue_position(CHR_2, CHR_2, CHR_2, CHR_2, CHR_P, CHR_2, LEN_OK, 8'd107, 8'd88, 8'd28);
    // no offset, largest degrees; minutes at 59 and at the 60 wrap
    queue_position(CHR_P, CHR_Y, CHR_P, CHR_Y, CHR_0, CHR_Y, LEN_OK, 8'd127, 8'd87, 8'd50);
    queue_position(CHR_3, CHR_3, CHR_3, CHR_3, CHR_3, CHR_3, LEN_OK, 8'd50, 8'd88, 8'd50);
    // length not six, also with bad info bytes: length wins
    queue_position(CHR_9, CHR_9, CHR_9, CHR_Y, CHR_Y, CHR_Y, 6'd0, 8'd60, 8'd60, 8'd60);
    queue_position(CHR_9, CHR_9, CHR_9, CHR_Y, CHR_Y, CHR_Y, 6'd5, 8'd0, 8'd255, 8'd27);
    queue_position(CHR_1, CHR_1, CHR_1, CHR_1, CHR_1, CHR_1, 6'd7, 8'd60, 8'd60, 8'd60);
    queue_position(CHR_1, CHR_1, CHR_1, CHR_1, CHR_1, CHR_1, 6'd63, 8'd60, 8'd60, 8'd60);
    // each info byte out of range, latitude still decoded
    queue_position(CHR_5, CHR_0, CHR_3, CHR_Y, CHR_P, CHR_P, LEN_OK, 8'd27, 8'd60, 8'd60);
    queue_position(CHR_5, CHR_0, CHR_3, CHR_0, CHR_P, CHR_P, LEN_OK, 8'd60, 8'd128, 8'd60);
    queue_position(CHR_9, CHR_9, CHR_9, CHR_9, CHR_9, CHR_9, LEN_OK, 8'd60, 8'd60, 8'd0);
    queue_position(CHR_9, CHR_9, CHR_9, CHR_Y, CHR_9, CHR_9, LEN_OK, 8'd255, 8'd60, 8'd60);
    // characters outside every set give zero digit and clear flag
    queue_position(8'h00, 8'hff, 8'h2f, 8'h3a, 8'h40, 8'h4f, LEN_OK, 8'd90, 8'd90, 8'd90);
    queue_position(8'h5b, 8'h60, 8'h7a, 8'h80, 8'hc5, 8'h5b, LEN_OK, 8'd29, 8'd126, 8'd29);
    // edge letters of each digit range
    queue_position(CHR_J, CHR_A, CHR_9, CHR_P, CHR_Y, CHR_A, LEN_OK, 8'd28, 8'd127, 8'd127);

    for (n = 0; n < RANDOM_ITEMS; n++) queue_random_position();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // every position in, every fix out, then a short drain for strays
    while (positions_accepted != positions_queued) @(posedge clk);
    while (expected_fix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

endmodule
